@@ rtl/skc_pkg.sv @@
// Package for the shift-chain key-change scanner.
// Holds shared constants, register indexes and types; no dependencies.
`timescale 1ns / 1ps

package skc_pkg;

  localparam int unsigned ChainsDef      = 6;
  localparam int unsigned BitsPerChainDef = 8;
  localparam int unsigned DataW          = 6;
  localparam int unsigned KeyIdxW        = 6;
  localparam int unsigned QueueDepth     = 2;
  localparam int unsigned CfgIdxW        = 1;

  localparam logic [CfgIdxW-1:0] CfgPressEn   = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgReleaseEn = 1'd1;

  typedef enum logic {
    BK_IDLE,
    BK_SCAN
  } back_state_e;

  typedef struct packed {
    logic press_en;
    logic release_en;
  } event_cfg_t;

endpackage

@@ rtl/skc_queue.sv @@
// Short request queue between scanner front and back.
// Register-based FIFO; uses skc_pkg only for its default depth.
`timescale 1ns / 1ps

module skc_queue
  import skc_pkg::*;
#(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  input  logic             pop_i,
  output logic [Width-1:0] pop_data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i || pop_i) else $error("queue push while full");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("queue pop while empty");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth)) else $error("queue count out of range");
`endif

endmodule

@@ rtl/skc_front.sv @@
// Scanner front: accepts shift steps and assembles the per-chain bytes.
// Pushes one key snapshot per completed scan; uses skc_pkg.
`timescale 1ns / 1ps

module skc_front
  import skc_pkg::*;
#(
  parameter int unsigned Chains       = ChainsDef,
  parameter int unsigned BitsPerChain = BitsPerChainDef,
  localparam int unsigned Keys        = Chains * BitsPerChain
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_valid_i,
  output logic             step_ready_o,
  input  logic [DataW-1:0] data_bits_i,
  output logic             push_o,
  output logic [Keys-1:0]  push_data_o,
  input  logic             full_i
);

  localparam int unsigned StepW = (BitsPerChain > 1) ? $clog2(BitsPerChain) : 1;

  logic [BitsPerChain-1:0] chain_q [Chains];
  logic [BitsPerChain-1:0] chain_d [Chains];
  logic [StepW-1:0]        step_q, step_d;
  logic                    accept;
  logic                    scan_done;

  assign step_ready_o = !full_i;
  assign accept       = step_valid_i && step_ready_o;
  assign scan_done    = (step_q == StepW'(BitsPerChain - 1));
  assign push_o       = accept && scan_done;

  always_comb begin
    for (int c = 0; c < Chains; c++) begin
      if (BitsPerChain > 1) begin
        chain_d[c] = {chain_q[c][BitsPerChain-2:0], 1'b0};
      end else begin
        chain_d[c] = '0;
      end
      chain_d[c][0] = (c < DataW) ? data_bits_i[c % DataW] : 1'b0;
      push_data_o[c*BitsPerChain +: BitsPerChain] = chain_d[c];
    end
  end

  always_comb begin
    step_d = step_q;
    if (accept) begin
      step_d = scan_done ? '0 : step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      for (int c = 0; c < Chains; c++) begin
        chain_q[c] <= '0;
      end
    end else begin
      step_q <= step_d;
      if (accept) begin
        for (int c = 0; c < Chains; c++) begin
          chain_q[c] <= scan_done ? '0 : chain_d[c];
        end
      end
    end
  end

endmodule

@@ rtl/skc_back.sv @@
// Scanner back: compares a snapshot with the stored key states and walks
// the keys in ascending order, one per cycle unless an event waits on the output, emitting events; uses skc_pkg.
`timescale 1ns / 1ps

module skc_back
  import skc_pkg::*;
#(
  parameter int unsigned Keys = ChainsDef * BitsPerChainDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  event_cfg_t         cfg_i,
  input  logic               empty_i,
  input  logic [Keys-1:0]    snap_i,
  output logic               pop_o,
  output logic               ev_valid_o,
  input  logic               ev_ready_i,
  output logic [KeyIdxW-1:0] ev_key_o,
  output logic               ev_pressed_o,
  output logic               ev_last_o
);

  localparam int unsigned KeyW = (Keys > 1) ? $clog2(Keys) : 1;

  back_state_e       state_q, state_d;
  logic [Keys-1:0]   prev_q;
  logic [Keys-1:0]   now_q;
  logic [Keys-1:0]   mask_q, mask_d;
  logic [KeyW-1:0]   idx_q, idx_d;
  logic [Keys-1:0]   rest;
  logic [Keys-1:0]   new_mask;
  logic              cur;
  logic              can_load;
  logic              load;
  logic              advance;
  logic              out_valid_q;
  logic [KeyIdxW-1:0] out_key_q;
  logic              out_pressed_q;
  logic              out_last_q;

  assign new_mask = (snap_i & ~prev_q & {Keys{cfg_i.press_en}})
                  | (~snap_i & prev_q & {Keys{cfg_i.release_en}});
  assign cur      = mask_q[idx_q];
  assign rest     = mask_q & ~(Keys'(1) << idx_q);
  assign can_load = !out_valid_q || ev_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          state_d = BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (advance && (rest == '0)) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    pop_o   = 1'b0;
    load    = 1'b0;
    advance = 1'b0;
    mask_d  = mask_q;
    idx_d   = idx_q;
    case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          pop_o  = 1'b1;
          mask_d = new_mask;
          idx_d  = '0;
        end
      end
      BK_SCAN: begin
        load    = cur && can_load;
        advance = !cur || can_load;
        if (load) begin
          mask_d = rest;
        end
        if (advance) begin
          idx_d = idx_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      prev_q      <= '0;
      mask_q      <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      mask_q  <= mask_d;
      idx_q   <= idx_d;
      if (pop_o) begin
        prev_q <= snap_i;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (ev_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      now_q <= snap_i;
    end
    if (load) begin
      out_key_q     <= KeyIdxW'(idx_q);
      out_pressed_q <= now_q[idx_q];
      out_last_q    <= (rest == '0);
    end
  end

  assign ev_valid_o   = out_valid_q;
  assign ev_key_o     = out_key_q;
  assign ev_pressed_o = out_pressed_q;
  assign ev_last_o    = out_last_q;

`ifndef SYNTHESIS
  a_idle_mask_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_IDLE |-> mask_q == '0) else $error("pending events left in idle");
  a_load_only_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> state_q == BK_SCAN && !pop_o) else $error("event load outside scan");
`endif

endmodule

@@ rtl/shift_chain_key_change_scanner.sv @@
// Shift-chain key-change scanner, top level: config registers, front, queue, back.
// Path: a completed scan's snapshot goes through the queue to the back, which walks its keys
// and registers each event for the output; events leave at most one per cycle.
// Throughput: a shift step is taken every cycle while the two-entry queue has room;
// the back pops a new snapshot only after its key walk for the previous one is done.
// Reset: asynchronous, active low; clears key states, chain bytes, queue and enables.
`timescale 1ns / 1ps

module shift_chain_key_change_scanner
  import skc_pkg::*;
#(
  parameter int unsigned Chains       = ChainsDef,
  parameter int unsigned BitsPerChain = BitsPerChainDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic               cfg_wdata_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // [5:0] data_bits
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [7:0]         m_axis_tdata,   // [5:0] key_index, [6] pressed
  output logic               m_axis_tlast
);

  localparam int unsigned Keys = Chains * BitsPerChain;

  event_cfg_t         cfg_q;
  logic               push;
  logic [Keys-1:0]    push_data;
  logic               pop;
  logic [Keys-1:0]    pop_data;
  logic               q_full;
  logic               q_empty;
  logic [KeyIdxW-1:0] ev_key;
  logic               ev_pressed;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgPressEn:   cfg_q.press_en   <= cfg_wdata_i;
        CfgReleaseEn: cfg_q.release_en <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  skc_front #(
    .Chains       (Chains),
    .BitsPerChain (BitsPerChain)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_valid_i (s_axis_tvalid),
    .step_ready_o (s_axis_tready),
    .data_bits_i  (s_axis_tdata[DataW-1:0]),
    .push_o       (push),
    .push_data_o  (push_data),
    .full_i       (q_full)
  );

  skc_queue #(
    .Width (Keys),
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  skc_back #(
    .Keys (Keys)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .empty_i      (q_empty),
    .snap_i       (pop_data),
    .pop_o        (pop),
    .ev_valid_o   (m_axis_tvalid),
    .ev_ready_i   (m_axis_tready),
    .ev_key_o     (ev_key),
    .ev_pressed_o (ev_pressed),
    .ev_last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, ev_pressed, ev_key};

endmodule
